>>> rtl/rvdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rvdec_pkg;

   localparam int XLEN      = 64;
   localparam int ADDR_BITS = 32;

   // Result immediate is sign-extended to XLEN and zero above it.
   localparam logic [63:0] IMM_MASK =
      (XLEN >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << XLEN) - 64'd1);
   localparam logic [31:0] PC_MASK =
      (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

   // Major opcodes (instruction bits 6:2).
   localparam logic [4:0] MAJ_AMO     = 5'h0B;
   localparam logic [4:0] MAJ_OP      = 5'h0C;
   localparam logic [4:0] MAJ_OPIMM   = 5'h04;
   localparam logic [4:0] MAJ_OPIMM32 = 5'h06;
   localparam logic [4:0] MAJ_OP32    = 5'h0E;
   localparam logic [4:0] MAJ_AUIPC   = 5'h05;
   localparam logic [4:0] MAJ_BRANCH  = 5'h18;

   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [5:0] F6_BASE   = 6'h00;
   localparam logic [5:0] F6_SRAI   = 6'h10;

   localparam logic [2:0] F3_ADD   = 3'd0;
   localparam logic [2:0] F3_SLL   = 3'd1;
   localparam logic [2:0] F3_AMO_W = 3'd2;
   localparam logic [2:0] F3_AMO_D = 3'd3;
   localparam logic [2:0] F3_SR    = 3'd5;

   localparam logic [3:0] AMO_KIND_NONE = 4'd0;
   localparam logic [3:0] AMO_KIND_LR   = 4'd3;

   typedef enum logic [2:0] {
      FMT_NONE = 3'd0,
      FMT_R    = 3'd1,
      FMT_I    = 3'd2,
      FMT_U    = 3'd3,
      FMT_SB   = 3'd4
   } fmt_type;

   localparam logic [6:0] OPC_NONE  = 7'd0;
   localparam logic [6:0] OPC_SUB   = 7'd24;
   localparam logic [6:0] OPC_SRA   = 7'd30;
   localparam logic [6:0] OPC_MUL   = 7'd33;
   localparam logic [6:0] OPC_SLLI  = 7'd42;
   localparam logic [6:0] OPC_SRLI  = 7'd46;
   localparam logic [6:0] OPC_SRAI  = 7'd47;
   localparam logic [6:0] OPC_ADDIW = 7'd50;
   localparam logic [6:0] OPC_SLLIW = 7'd51;
   localparam logic [6:0] OPC_SRLIW = 7'd52;
   localparam logic [6:0] OPC_SRAIW = 7'd53;
   localparam logic [6:0] OPC_ADDW  = 7'd54;
   localparam logic [6:0] OPC_SUBW  = 7'd55;
   localparam logic [6:0] OPC_SLLW  = 7'd56;
   localparam logic [6:0] OPC_SRLW  = 7'd57;
   localparam logic [6:0] OPC_SRAW  = 7'd58;
   localparam logic [6:0] OPC_AUIPC = 7'd64;

   // AMO funct5 to operation kind; zero marks an unused funct5.
   localparam logic [3:0] AMO_KIND [32] = '{
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0, 4'd0, 4'd0,
      4'd6, 4'd0, 4'd0, 4'd0, 4'd7, 4'd0, 4'd0, 4'd0,
      4'd8, 4'd0, 4'd0, 4'd0, 4'd9, 4'd0, 4'd0, 4'd0,
      4'd10, 4'd0, 4'd0, 4'd0, 4'd11, 4'd0, 4'd0, 4'd0
   };
   localparam logic [6:0] OP_BASE_CODE [8] = '{
      7'd23, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd31, 7'd32
   };
   localparam logic [6:0] OPIMM_CODE [8] = '{
      7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd0, 7'd48, 7'd49
   };
   localparam logic [6:0] OP32_MULDIV_CODE [8] = '{
      7'd59, 7'd0, 7'd0, 7'd0, 7'd60, 7'd61, 7'd62, 7'd63
   };
   localparam logic [6:0] BRANCH_CODE [8] = '{
      7'd65, 7'd66, 7'd0, 7'd0, 7'd67, 7'd68, 7'd69, 7'd70
   };

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] fetch_pc;
      logic        fetch_fault;
      logic        exec_allowed;
      logic        from_debug_buffer;
   } req_type;

   typedef struct packed {
      logic [6:0]         op_code;
      logic [2:0]         format_class;
      logic [5:0]         src1_reg;
      logic [5:0]         src2_reg;
      logic [5:0]         dest_reg;
      logic signed [63:0] immediate;
      logic               illegal;
      logic               short_form;
      logic [31:0]        pc_out;
      logic               fault_out;
      logic               exec_out;
      logic               debug_out;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/rvdec_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rvdec_req_if;
   import rvdec_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rvdec_rsp_if;
   import rvdec_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/rv64_ima_instruction_decoder.sv
// Each accepted item is held in the input register, decoded, and held again
// in the result register. Throughput: one item per cycle while the response
// side is ready; each register advances whenever the stage after it is empty
// or being drained. Reset is synchronous and active high; it empties both
// stages and leaves the payload registers as they are.
`timescale 1ns / 1ps
`default_nettype none
module rv64_ima_instruction_decoder (
   input wire logic  clock,
   input wire logic  reset,
   rvdec_req_if.sink   req_chan,
   rvdec_rsp_if.source rsp_chan
);
   import rvdec_pkg::*;

   // Stage one holds the fetched item exactly as it arrived. Stage two holds
   // the decoded response item until the consumer takes it.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic    s1_ready;
   logic    s2_ready;

   // A stage may load when it is empty or when its content leaves this cycle.
   assign s2_ready = !rsp_valid_ff || rsp_chan.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign req_chan.ready   = s1_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign s1_valid_in  = s1_ready ? req_chan.valid : s1_valid_ff;
   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;

   // Decode of the word held in stage one.
   logic [31:0] w;
   logic [4:0]  maj;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [5:0]  f6;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [4:0]  rd;
   logic [3:0]  amo_kind;
   logic [63:0] imm_i;
   logic [63:0] imm_u;
   logic [63:0] imm_b;
   logic [6:0]  code;
   fmt_type     fmt;
   logic [5:0]  s1_reg;
   logic [5:0]  s2_reg;
   logic [5:0]  d_reg;
   logic [63:0] imm;
   logic        err;

   assign w        = s1_data_ff.instr_word;
   assign maj      = w[6:2];
   assign f3       = w[14:12];
   assign f7       = w[31:25];
   assign f6       = w[31:26];
   assign rs1      = w[19:15];
   assign rs2      = w[24:20];
   assign rd       = w[11:7];
   assign amo_kind = AMO_KIND[w[31:27]];
   assign imm_i    = {{52{w[31]}}, w[31:20]};
   assign imm_u    = {{32{w[31]}}, w[31:12], 12'b0};
   assign imm_b    = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};

   always_comb begin
      code   = OPC_NONE;
      fmt    = FMT_NONE;
      s1_reg = 6'd0;
      s2_reg = 6'd0;
      d_reg  = 6'd0;
      imm    = 64'd0;
      err    = 1'b0;
      unique case (maj)
         MAJ_AMO: begin
            fmt    = FMT_R;
            s1_reg = {1'b0, rs1};
            s2_reg = {1'b0, rs2};
            d_reg  = {1'b0, rd};
            // LR reads memory only, so a nonzero rs2 field is rejected.
            if ((amo_kind == AMO_KIND_NONE) || ((f3 != F3_AMO_W) && (f3 != F3_AMO_D))
                  || ((amo_kind == AMO_KIND_LR) && (rs2 != 5'd0))) begin
               err = 1'b1;
            end else begin
               // Word forms take odd numbers and doubleword forms the next even.
               code = 7'({amo_kind - 4'd1, 1'b0}) + ((f3 == F3_AMO_W) ? 7'd1 : 7'd2);
            end
         end
         MAJ_OP: begin
            fmt    = FMT_R;
            s1_reg = {1'b0, rs1};
            s2_reg = {1'b0, rs2};
            d_reg  = {1'b0, rd};
            priority if (f7 == F7_BASE) begin
               code = OP_BASE_CODE[f3];
            end else if (f7 == F7_MULDIV) begin
               code = OPC_MUL + {4'd0, f3};
            end else if ((f7 == F7_ALT) && (f3 == F3_ADD)) begin
               code = OPC_SUB;
            end else if ((f7 == F7_ALT) && (f3 == F3_SR)) begin
               code = OPC_SRA;
            end else begin
               err = 1'b1;
            end
         end
         MAJ_OPIMM: begin
            fmt    = FMT_I;
            s1_reg = {1'b0, rs1};
            d_reg  = {1'b0, rd};
            imm    = imm_i;
            // Shifts carry a six-bit shift amount; the bits above it select
            // between logical and arithmetic right shift.
            priority if (f3 == F3_SLL) begin
               if (f6 == F6_BASE) code = OPC_SLLI;
               else               err  = 1'b1;
            end else if (f3 == F3_SR) begin
               priority if (f6 == F6_BASE)      code = OPC_SRLI;
               else if (f6 == F6_SRAI)          code = OPC_SRAI;
               else                             err  = 1'b1;
            end else begin
               code = OPIMM_CODE[f3];
            end
         end
         MAJ_OPIMM32: begin
            fmt    = FMT_I;
            s1_reg = {1'b0, rs1};
            d_reg  = {1'b0, rd};
            imm    = imm_i;
            priority if (f3 == F3_ADD)                       code = OPC_ADDIW;
            else if ((f3 == F3_SLL) && (f7 == F7_BASE))      code = OPC_SLLIW;
            else if ((f3 == F3_SR) && (f7 == F7_BASE))       code = OPC_SRLIW;
            else if ((f3 == F3_SR) && (f7 == F7_ALT))        code = OPC_SRAIW;
            else                                             err  = 1'b1;
         end
         MAJ_OP32: begin
            fmt    = FMT_R;
            s1_reg = {1'b0, rs1};
            s2_reg = {1'b0, rs2};
            d_reg  = {1'b0, rd};
            priority if (f7 == F7_MULDIV)                    code = OP32_MULDIV_CODE[f3];
            else if ((f7 == F7_BASE) && (f3 == F3_ADD))      code = OPC_ADDW;
            else if ((f7 == F7_ALT) && (f3 == F3_ADD))       code = OPC_SUBW;
            else if ((f7 == F7_BASE) && (f3 == F3_SLL))      code = OPC_SLLW;
            else if ((f7 == F7_BASE) && (f3 == F3_SR))       code = OPC_SRLW;
            else if ((f7 == F7_ALT) && (f3 == F3_SR))        code = OPC_SRAW;
            else                                             code = OPC_NONE;
            // Unused multiply-divide funct3 values land here as well.
            if (code == OPC_NONE) err = 1'b1;
         end
         MAJ_AUIPC: begin
            fmt   = FMT_U;
            d_reg = {1'b0, rd};
            imm   = imm_u;
            code  = OPC_AUIPC;
         end
         MAJ_BRANCH: begin
            fmt    = FMT_SB;
            s1_reg = {1'b0, rs1};
            s2_reg = {1'b0, rs2};
            imm    = imm_b;
            code   = BRANCH_CODE[f3];
            if (code == OPC_NONE) err = 1'b1;
         end
         default: begin
            // Major opcodes outside the supported set decode to nothing.
            code = OPC_NONE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in.op_code      = code;
      rsp_data_in.format_class = fmt;
      rsp_data_in.src1_reg     = s1_reg;
      rsp_data_in.src2_reg     = s2_reg;
      rsp_data_in.dest_reg     = d_reg;
      rsp_data_in.immediate    = imm & IMM_MASK;
      rsp_data_in.illegal      = err;
      rsp_data_in.short_form   = (w[1:0] != 2'b11);
      rsp_data_in.pc_out       = s1_data_ff.fetch_pc & PC_MASK;
      rsp_data_in.fault_out    = s1_data_ff.fetch_fault;
      rsp_data_in.exec_out     = s1_data_ff.exec_allowed;
      rsp_data_in.debug_out    = s1_data_ff.from_debug_buffer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_data_ff <= req_chan.payload;
      end
      if (s2_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // Backpressure on the request side only when both stages hold an item.
   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free stage");

   // An item in stage one is never dropped while the response is stalled.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("stage one item lost under stall");

   // A taken response with nothing behind it leaves the output empty.
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_chan.ready && !s1_valid_ff) |=> !rsp_valid_ff)
      else $error("response repeated after it was taken");

   // An illegal encoding never carries an instruction number.
   a_illegal_no_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.illegal) |-> (rsp_data_ff.op_code == OPC_NONE))
      else $error("illegal item with a nonzero op code");
`endif

endmodule
`default_nettype wire

>>> verif/tb_rv64_ima_instruction_decoder.sv
`timescale 1ns / 1ps
module tb_rv64_ima_instruction_decoder;
   import rvdec_pkg::*;

   // Dense instruction numbers in the order the decoder assigns them. The list
   // starts at zero, so every member's value is its position.
   typedef enum logic [6:0] {
      OC_NONE,
      OC_AMOADD_W, OC_AMOADD_D, OC_AMOSWAP_W, OC_AMOSWAP_D, OC_LR_W, OC_LR_D,
      OC_SC_W, OC_SC_D, OC_AMOXOR_W, OC_AMOXOR_D, OC_AMOOR_W, OC_AMOOR_D,
      OC_AMOAND_W, OC_AMOAND_D, OC_AMOMIN_W, OC_AMOMIN_D, OC_AMOMAX_W,
      OC_AMOMAX_D, OC_AMOMINU_W, OC_AMOMINU_D, OC_AMOMAXU_W, OC_AMOMAXU_D,
      OC_ADD, OC_SUB, OC_SLL, OC_SLT, OC_SLTU, OC_XOR, OC_SRL, OC_SRA, OC_OR,
      OC_AND, OC_MUL, OC_MULH, OC_MULHSU, OC_MULHU, OC_DIV, OC_DIVU, OC_REM,
      OC_REMU,
      OC_ADDI, OC_SLLI, OC_SLTI, OC_SLTIU, OC_XORI, OC_SRLI, OC_SRAI, OC_ORI,
      OC_ANDI,
      OC_ADDIW, OC_SLLIW, OC_SRLIW, OC_SRAIW,
      OC_ADDW, OC_SUBW, OC_SLLW, OC_SRLW, OC_SRAW, OC_MULW, OC_DIVW, OC_DIVUW,
      OC_REMW, OC_REMUW,
      OC_AUIPC, OC_BEQ, OC_BNE, OC_BLT, OC_BGE, OC_BLTU, OC_BGEU
   } op_code_type;

   // AMO funct5 values (instruction bits 31:27).
   localparam logic [4:0] A5_ADD  = 5'h00;
   localparam logic [4:0] A5_SWAP = 5'h01;
   localparam logic [4:0] A5_LR   = 5'h02;
   localparam logic [4:0] A5_SC   = 5'h03;
   localparam logic [4:0] A5_XOR  = 5'h04;
   localparam logic [4:0] A5_OR   = 5'h08;
   localparam logic [4:0] A5_AND  = 5'h0C;
   localparam logic [4:0] A5_MIN  = 5'h10;
   localparam logic [4:0] A5_MAX  = 5'h14;
   localparam logic [4:0] A5_MINU = 5'h18;
   localparam logic [4:0] A5_MAXU = 5'h1C;

   // funct3 values that the package does not name.
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_DIV  = 3'd4;
   localparam logic [2:0] F3_DIVU = 3'd5;
   localparam logic [2:0] F3_REM  = 3'd6;
   localparam logic [2:0] F3_REMU = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // Pools that the random generator draws legal encodings from.
   localparam logic [4:0] HANDLED_MAJ [7] = '{
      MAJ_AMO, MAJ_OP, MAJ_OPIMM, MAJ_OPIMM32, MAJ_OP32, MAJ_AUIPC, MAJ_BRANCH
   };
   localparam logic [4:0] AMO_FUNCT5 [11] = '{
      A5_ADD, A5_SWAP, A5_LR, A5_SC, A5_XOR, A5_OR, A5_AND,
      A5_MIN, A5_MAX, A5_MINU, A5_MAXU
   };
   localparam logic [6:0] FUNCT7_SET [3]   = '{F7_BASE, F7_MULDIV, F7_ALT};
   localparam logic [2:0] WORD_F3 [3]      = '{F3_ADD, F3_SLL, F3_SR};
   localparam logic [2:0] WORD_MD_F3 [5]   = '{F3_ADD, F3_DIV, F3_DIVU, F3_REM, F3_REMU};
   localparam logic [2:0] BRANCH_F3 [6]    = '{
      F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU
   };

   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 8;

   // One row of the directed table. When pinned is set, rsp holds the result
   // written out by hand; otherwise the row is checked against the decoder
   // model below.
   typedef struct packed {
      req_type stim;
      logic    pinned;
      rsp_type rsp;
   } dir_row_type;

   localparam int DIR_ROWS = 26;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // All-zero word: unhandled major opcode, low bits flag a compressed word.
      '{'{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{default: '0, short_form: 1'b1}},
      // All-ones word and pc: unhandled major opcode, every flag passed through.
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{default: '0, pc_out: 32'hFFFF_FFFF, fault_out: 1'b1, exec_out: 1'b1,
          debug_out: 1'b1}},
      // Branch with funct3 two is illegal but keeps its format.
      '{'{32'h0000_2063, 32'h8000_0000, 1'b0, 1'b1, 1'b0}, 1'b1,
        '{default: '0, format_class: FMT_SB, illegal: 1'b1, pc_out: 32'h8000_0000,
          exec_out: 1'b1}},
      // LR.W with a nonzero rs2 is illegal.
      '{'{32'h1010_202F, 32'h0000_1000, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{default: '0, format_class: FMT_R, src2_reg: 6'd1, illegal: 1'b1,
          pc_out: 32'h0000_1000, debug_out: 1'b1}},
      '{'{32'h0020_A0AF, 32'h0000_0004, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h1002_B1AF, 32'h1234_5678, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{32'h2800_202F, 32'h0000_0008, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{32'h0000_002F, 32'h0000_000C, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{32'hE600_302F, 32'hFFFF_FFFC, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h41FF_8FB3, 32'h8000_0004, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h4000_5033, 32'h0000_0010, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{32'h0200_3033, 32'h0000_0014, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{32'h4000_1033, 32'h0000_0018, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'hFFF0_0013, 32'h0000_001C, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h0400_1013, 32'h0000_0020, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{32'h43F0_5013, 32'h0000_0024, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{32'h7FF0_001B, 32'h0000_0028, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{32'h4000_501B, 32'h0000_002C, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{32'h0200_101B, 32'h0000_0030, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h0200_703B, 32'h0000_0034, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{32'h0200_103B, 32'h0000_0038, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{32'h4000_103B, 32'h0000_003C, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h8000_0017, 32'h7FFF_FFFC, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{32'h8000_0063, 32'h0000_0040, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{32'hFFFF_FFE3, 32'h0000_0044, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{32'h0000_0010, 32'h0000_0046, 1'b0, 1'b1, 1'b0}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   rvdec_req_if req_chan();
   rvdec_rsp_if rsp_chan();

   rv64_ima_instruction_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Decoded results that the block still owes, oldest first.
   rsp_type decoded_q [$];
   int      fail_count = 0;
   bit      stall_en = 1'b1;

   // The hand-written result travels with the item it belongs to, so that the
   // monitor sees both in the same cycle.
   logic    req_pinned = 1'b0;
   rsp_type pinned_rsp = '0;

   // Decoder model: works out the result for one fetched instruction.
   function automatic rsp_type decode_instr(input req_type r);
      logic [31:0] w;
      logic [4:0]  maj;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [5:0]  f6;
      logic        dbl;
      logic        bad;
      logic [63:0] imm;
      op_code_type code;
      fmt_type     fmt;
      rsp_type     o;

      w    = r.instr_word;
      maj  = w[6:2];
      f3   = w[14:12];
      f7   = w[31:25];
      f6   = w[31:26];
      dbl  = (f3 == F3_AMO_D);
      bad  = 1'b0;
      imm  = '0;
      code = OC_NONE;
      fmt  = FMT_NONE;

      case (maj)
         MAJ_AMO: begin
            fmt = FMT_R;
            case (w[31:27])
               A5_ADD:  code = dbl ? OC_AMOADD_D  : OC_AMOADD_W;
               A5_SWAP: code = dbl ? OC_AMOSWAP_D : OC_AMOSWAP_W;
               A5_LR:   code = dbl ? OC_LR_D      : OC_LR_W;
               A5_SC:   code = dbl ? OC_SC_D      : OC_SC_W;
               A5_XOR:  code = dbl ? OC_AMOXOR_D  : OC_AMOXOR_W;
               A5_OR:   code = dbl ? OC_AMOOR_D   : OC_AMOOR_W;
               A5_AND:  code = dbl ? OC_AMOAND_D  : OC_AMOAND_W;
               A5_MIN:  code = dbl ? OC_AMOMIN_D  : OC_AMOMIN_W;
               A5_MAX:  code = dbl ? OC_AMOMAX_D  : OC_AMOMAX_W;
               A5_MINU: code = dbl ? OC_AMOMINU_D : OC_AMOMINU_W;
               A5_MAXU: code = dbl ? OC_AMOMAXU_D : OC_AMOMAXU_W;
               default: bad = 1'b1;
            endcase
            // Only word and doubleword widths exist, and LR reads no rs2.
            if (f3 != F3_AMO_W && f3 != F3_AMO_D)
               bad = 1'b1;
            if (w[31:27] == A5_LR && w[24:20] != 5'd0)
               bad = 1'b1;
         end
         MAJ_OP: begin
            fmt = FMT_R;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  code = OC_ADD;
                  F3_SLL:  code = OC_SLL;
                  F3_SLT:  code = OC_SLT;
                  F3_SLTU: code = OC_SLTU;
                  F3_XOR:  code = OC_XOR;
                  F3_SR:   code = OC_SRL;
                  F3_OR:   code = OC_OR;
                  default: code = OC_AND;
               endcase
            end else if (f7 == F7_MULDIV) begin
               // The M extension numbers follow funct3 in order.
               code = op_code_type'(OC_MUL + {4'd0, f3});
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               code = OC_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SR) begin
               code = OC_SRA;
            end else begin
               bad = 1'b1;
            end
         end
         MAJ_OPIMM: begin
            fmt = FMT_I;
            imm = {{52{w[31]}}, w[31:20]};
            case (f3)
               F3_ADD:  code = OC_ADDI;
               F3_SLL: begin
                  if (f6 == F6_BASE) code = OC_SLLI;
                  else bad = 1'b1;
               end
               F3_SLT:  code = OC_SLTI;
               F3_SLTU: code = OC_SLTIU;
               F3_XOR:  code = OC_XORI;
               F3_SR: begin
                  if (f6 == F6_BASE) code = OC_SRLI;
                  else if (f6 == F6_SRAI) code = OC_SRAI;
                  else bad = 1'b1;
               end
               F3_OR:   code = OC_ORI;
               default: code = OC_ANDI;
            endcase
         end
         MAJ_OPIMM32: begin
            fmt = FMT_I;
            imm = {{52{w[31]}}, w[31:20]};
            if (f3 == F3_ADD) code = OC_ADDIW;
            else if (f3 == F3_SLL && f7 == F7_BASE) code = OC_SLLIW;
            else if (f3 == F3_SR && f7 == F7_BASE) code = OC_SRLIW;
            else if (f3 == F3_SR && f7 == F7_ALT) code = OC_SRAIW;
            else bad = 1'b1;
         end
         MAJ_OP32: begin
            fmt = FMT_R;
            if (f7 == F7_MULDIV) begin
               case (f3)
                  F3_ADD:  code = OC_MULW;
                  F3_DIV:  code = OC_DIVW;
                  F3_DIVU: code = OC_DIVUW;
                  F3_REM:  code = OC_REMW;
                  F3_REMU: code = OC_REMUW;
                  default: bad = 1'b1;
               endcase
            end else if (f7 == F7_BASE && f3 == F3_ADD) code = OC_ADDW;
            else if (f7 == F7_ALT && f3 == F3_ADD) code = OC_SUBW;
            else if (f7 == F7_BASE && f3 == F3_SLL) code = OC_SLLW;
            else if (f7 == F7_BASE && f3 == F3_SR) code = OC_SRLW;
            else if (f7 == F7_ALT && f3 == F3_SR) code = OC_SRAW;
            else bad = 1'b1;
         end
         MAJ_AUIPC: begin
            fmt  = FMT_U;
            code = OC_AUIPC;
            imm  = {{32{w[31]}}, w[31:12], 12'h000};
         end
         MAJ_BRANCH: begin
            fmt = FMT_SB;
            imm = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            case (f3)
               F3_BEQ:  code = OC_BEQ;
               F3_BNE:  code = OC_BNE;
               F3_BLT:  code = OC_BLT;
               F3_BGE:  code = OC_BGE;
               F3_BLTU: code = OC_BLTU;
               F3_BGEU: code = OC_BGEU;
               default: bad = 1'b1;
            endcase
         end
         default: ;
      endcase

      // An illegal word keeps its format, registers and immediate.
      if (bad)
         code = OC_NONE;

      o.op_code      = code;
      o.format_class = fmt;
      o.src1_reg     = (fmt == FMT_R || fmt == FMT_I || fmt == FMT_SB) ?
                       {1'b0, w[19:15]} : 6'd0;
      o.src2_reg     = (fmt == FMT_R || fmt == FMT_SB) ? {1'b0, w[24:20]} : 6'd0;
      o.dest_reg     = (fmt == FMT_R || fmt == FMT_I || fmt == FMT_U) ?
                       {1'b0, w[11:7]} : 6'd0;
      o.immediate    = imm & IMM_MASK;
      o.illegal      = bad;
      o.short_form   = (w[1:0] != 2'b11);
      o.pc_out       = r.fetch_pc & PC_MASK;
      o.fault_out    = r.fetch_fault;
      o.exec_out     = r.exec_allowed;
      o.debug_out    = r.from_debug_buffer;
      return o;
   endfunction

   // Builds a random instruction word. Most words carry a handled major
   // opcode with legal funct fields and random registers and immediates; the
   // rest are raw noise or have their funct fields left random, which lands
   // on the illegal encodings.
   function automatic logic [31:0] make_instr();
      logic [31:0] w;
      logic [4:0]  maj;

      w = $urandom;
      if ($urandom_range(99) < 15)
         return w;
      maj    = HANDLED_MAJ[$urandom_range(6)];
      w[6:2] = maj;
      w[1:0] = ($urandom_range(99) < 10) ? 2'($urandom) : 2'b11;
      if ($urandom_range(99) < 85) begin
         case (maj)
            MAJ_AMO: begin
               w[31:27] = AMO_FUNCT5[$urandom_range(10)];
               w[14:12] = $urandom_range(1) ? F3_AMO_D : F3_AMO_W;
               if (w[31:27] == A5_LR && $urandom_range(3) != 0)
                  w[24:20] = 5'd0;
            end
            MAJ_OP: begin
               w[31:25] = FUNCT7_SET[$urandom_range(2)];
               if (w[31:25] == F7_ALT)
                  w[14:12] = $urandom_range(1) ? F3_SR : F3_ADD;
            end
            MAJ_OPIMM: begin
               if (w[14:12] == F3_SLL)
                  w[31:26] = F6_BASE;
               else if (w[14:12] == F3_SR)
                  w[31:26] = $urandom_range(1) ? F6_SRAI : F6_BASE;
            end
            MAJ_OPIMM32: begin
               w[14:12] = WORD_F3[$urandom_range(2)];
               if (w[14:12] == F3_SLL)
                  w[31:25] = F7_BASE;
               else if (w[14:12] == F3_SR)
                  w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
            end
            MAJ_OP32: begin
               w[31:25] = FUNCT7_SET[$urandom_range(2)];
               if (w[31:25] == F7_MULDIV)
                  w[14:12] = WORD_MD_F3[$urandom_range(4)];
               else if (w[31:25] == F7_BASE)
                  w[14:12] = WORD_F3[$urandom_range(2)];
               else
                  w[14:12] = $urandom_range(1) ? F3_SR : F3_ADD;
            end
            MAJ_BRANCH: w[14:12] = BRANCH_F3[$urandom_range(5)];
            default: ;
         endcase
      end
      return w;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_decode(input rsp_type want, input rsp_type got);
      compare_field("op_code", 64'(want.op_code), 64'(got.op_code));
      compare_field("format_class", 64'(want.format_class), 64'(got.format_class));
      compare_field("src1_reg", 64'(want.src1_reg), 64'(got.src1_reg));
      compare_field("src2_reg", 64'(want.src2_reg), 64'(got.src2_reg));
      compare_field("dest_reg", 64'(want.dest_reg), 64'(got.dest_reg));
      compare_field("immediate", want.immediate, got.immediate);
      compare_field("illegal", 64'(want.illegal), 64'(got.illegal));
      compare_field("short_form", 64'(want.short_form), 64'(got.short_form));
      compare_field("pc_out", 64'(want.pc_out), 64'(got.pc_out));
      compare_field("fault_out", 64'(want.fault_out), 64'(got.fault_out));
      compare_field("exec_out", 64'(want.exec_out), 64'(got.exec_out));
      compare_field("debug_out", 64'(want.debug_out), 64'(got.debug_out));
   endtask

   // Monitor for both channels. Responses are checked before the item taken
   // in the same cycle is queued; with the input and result registers in
   // between, the two never refer to the same item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (decoded_q.size() == 0) begin
               $error("response item arrived with no instruction outstanding");
               fail_count++;
            end else begin
               check_decode(decoded_q.pop_front(), rsp_chan.payload);
            end
         end
         if (req_chan.valid && req_chan.ready)
            decoded_q.push_back(req_pinned ? pinned_rsp : decode_instr(req_chan.payload));
      end
   end

   // Result side back-pressure: ready is dropped at random, with an 8 percent
   // chance, while stalls are enabled.
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      rsp_chan.ready <= (stall_en && $urandom_range(99) < 8) ? 1'b0 : 1'b1;
   end

   // Offers one item and holds it until the block takes it. Random idle
   // cycles come first, so valid is only lowered in a step where it is not
   // raised again.
   task automatic send_item(input req_type r, input logic pin, input rsp_type want);
      while (stall_en && $urandom_range(99) < 8) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      req_pinned       <= pin;
      pinned_rsp       <= want;
      do
         @(posedge clock);
      while (!req_chan.ready);
   endtask

   initial begin
      req_type r;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: extremes of the fields, each major opcode and its
      // illegal corners, the LR rule and a compressed-looking word.
      for (int i = 0; i < DIR_ROWS; i++)
         send_item(DIR_TABLE[i].stim, DIR_TABLE[i].pinned, DIR_TABLE[i].rsp);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // A long stretch in the middle runs at full rate on both sides.
         stall_en = !(i >= 250 && i < 450);
         if (i == 500) begin
            // Let the pipeline empty out completely before going on.
            req_chan.valid <= 1'b0;
            @(posedge clock);
            wait (decoded_q.size() == 0);
            @(posedge clock);
         end
         r.instr_word        = make_instr();
         r.fetch_pc          = $urandom;
         r.fetch_fault       = 1'($urandom);
         r.exec_allowed      = 1'($urandom);
         r.from_debug_buffer = 1'($urandom);
         send_item(r, 1'b0, '0);
      end
      req_chan.valid <= 1'b0;
      req_pinned     <= 1'b0;

      @(posedge clock);
      wait (decoded_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[rv64_ima_instruction_decoder] OK");
      else
         $display("[rv64_ima_instruction_decoder] ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of under a thousand items.
   initial begin
      #(2_000_000);
      $display("[rv64_ima_instruction_decoder] ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/rvdec_pkg.sv
rtl/rvdec_if.sv
rtl/rv64_ima_instruction_decoder.sv
verif/tb_rv64_ima_instruction_decoder.sv
